[rtl/spp_pkg.sv]
// Shared constants for the sphere point sampler.
package spp_pkg;

   // Default fraction width of the uniform samples.
   localparam int SAMPLE_BITS_DEFAULT = 16;

   // Widths of the ports and their fields.
   localparam int FIELD_W    = 16;
   localparam int RADIUS_W   = 16;
   localparam int COORD_W    = 17;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 56;

   // Internal fixed-point widths.
   localparam int S30_W      = 31;
   localparam int RADICAND_W = 33;
   localparam int ROOT_W     = 17;
   localparam int REM_W      = 35;
   localparam int ZPROD_W    = S30_W + RADIUS_W;

   // One in Q.30.
   localparam logic [S30_W-1:0] Q30_ONE = 31'h4000_0000;

   // Depth of the queue between the front and the back.
   localparam int QUEUE_DEPTH = 4;

endpackage

[rtl/spp_front.sv]
// Front part: takes request words, forms the disc point and S, drops rejected pairs.
module spp_front #(
   parameter int SAMPLE_BITS = spp_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  logic [spp_pkg::FIELD_W-1:0]    first_uniform,
   input  logic [spp_pkg::FIELD_W-1:0]    second_uniform,
   input  logic [spp_pkg::RADIUS_W-1:0]   radius,
   output logic                           push_valid,
   input  logic                           push_ready,
   output logic [SAMPLE_BITS-1:0]         x_mag,
   output logic [SAMPLE_BITS-1:0]         y_mag,
   output logic                           x_neg,
   output logic                           y_neg,
   output logic [spp_pkg::RADIUS_W-1:0]   radius_out,
   output logic [spp_pkg::S30_W-1:0]      s_q30
);

   localparam int B    = SAMPLE_BITS;
   localparam int SQ_W = 2 * B;
   localparam logic [B-1:0]    HALF  = {1'b1, {(B-1){1'b0}}};
   localparam logic [SQ_W-1:0] S_ONE = SQ_W'(1) << (SQ_W - 2);

   logic en;

   logic                          a_valid_ff;
   logic [B-1:0]                  a_u_ff, a_v_ff, a_u_in, a_v_in;
   logic [spp_pkg::RADIUS_W-1:0]  a_r_ff;

   logic                          b_valid_ff;
   logic [B-1:0]                  b_xm_ff, b_ym_ff, b_xm_in, b_ym_in;
   logic                          b_xneg_ff, b_yneg_ff, b_xneg_in, b_yneg_in;
   logic [spp_pkg::RADIUS_W-1:0]  b_r_ff;

   logic                          c_valid_ff;
   logic [SQ_W-1:0]               c_sqx_ff, c_sqy_ff, c_sqx_in, c_sqy_in;
   logic [B-1:0]                  c_xm_ff, c_ym_ff;
   logic                          c_xneg_ff, c_yneg_ff;
   logic [spp_pkg::RADIUS_W-1:0]  c_r_ff;

   logic [SQ_W-1:0]               s_sum;
   logic                          reject;
   logic [31:0]                   s_wide;

   // The whole front moves together unless the queue refuses the last stage.
   assign en       = !c_valid_ff || push_ready;
   assign in_ready = en;

   // Keep only the sample bits of each uniform field.
   generate
      if (B <= spp_pkg::FIELD_W) begin : g_narrow
         assign a_u_in = first_uniform[B-1:0];
         assign a_v_in = second_uniform[B-1:0];
      end else begin : g_wide
         assign a_u_in = {{(B - spp_pkg::FIELD_W){1'b0}}, first_uniform};
         assign a_v_in = {{(B - spp_pkg::FIELD_W){1'b0}}, second_uniform};
      end
   endgenerate

   // Disc coordinates as sign and magnitude.
   assign b_xneg_in = ~a_u_ff[B-1];
   assign b_yneg_in = ~a_v_ff[B-1];
   assign b_xm_in   = b_xneg_in ? HALF - a_u_ff : a_u_ff - HALF;
   assign b_ym_in   = b_yneg_in ? HALF - a_v_ff : a_v_ff - HALF;

   // Squares of the magnitudes.
   assign c_sqx_in = SQ_W'(b_xm_ff) * SQ_W'(b_xm_ff);
   assign c_sqy_in = SQ_W'(b_ym_ff) * SQ_W'(b_ym_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_u_ff    <= a_u_in;
         a_v_ff    <= a_v_in;
         a_r_ff    <= radius;
         b_xm_ff   <= b_xm_in;
         b_ym_ff   <= b_ym_in;
         b_xneg_ff <= b_xneg_in;
         b_yneg_ff <= b_yneg_in;
         b_r_ff    <= a_r_ff;
         c_sqx_ff  <= c_sqx_in;
         c_sqy_ff  <= c_sqy_in;
         c_xm_ff   <= b_xm_ff;
         c_ym_ff   <= b_ym_ff;
         c_xneg_ff <= b_xneg_ff;
         c_yneg_ff <= b_yneg_ff;
         c_r_ff    <= b_r_ff;
      end
   end

   // S and the exact rejection test; S outside the unit disc is dropped here.
   assign s_sum  = c_sqx_ff + c_sqy_ff;
   assign reject = s_sum > S_ONE;

   // Bring S to thirty fraction bits.
   generate
      if (SQ_W >= 32) begin : g_shift_down
         assign s_wide = 32'(s_sum >> (SQ_W - 32));
      end else begin : g_shift_up
         assign s_wide = 32'(s_sum) << (32 - SQ_W);
      end
   endgenerate

   assign s_q30 = (s_wide > 32'(spp_pkg::Q30_ONE)) ? spp_pkg::Q30_ONE
                                                   : s_wide[spp_pkg::S30_W-1:0];

   assign push_valid = c_valid_ff && !reject;
   assign x_mag      = c_xm_ff;
   assign y_mag      = c_ym_ff;
   assign x_neg      = c_xneg_ff;
   assign y_neg      = c_yneg_ff;
   assign radius_out = c_r_ff;

endmodule

[rtl/spp_queue.sv]
// Short register queue between the front and the back.
module spp_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = spp_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = count_ff != CNT_W'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;
   assign pop_data   = slot_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[rtl/spp_back.sv]
// Back part: square root, scaling by the radius and signed output words.
module spp_back #(
   parameter int SAMPLE_BITS = spp_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  logic [SAMPLE_BITS-1:0]              x_mag,
   input  logic [SAMPLE_BITS-1:0]              y_mag,
   input  logic                                x_neg,
   input  logic                                y_neg,
   input  logic [spp_pkg::RADIUS_W-1:0]        radius,
   input  logic [spp_pkg::S30_W-1:0]           s_q30,
   output logic                                out_valid,
   input  logic                                out_ready,
   output logic signed [spp_pkg::COORD_W-1:0]  coord_x,
   output logic signed [spp_pkg::COORD_W-1:0]  coord_y,
   output logic signed [spp_pkg::COORD_W-1:0]  coord_z
);

   localparam int B      = SAMPLE_BITS;
   localparam int XR_W   = B + spp_pkg::RADIUS_W;
   localparam int PROD_W = XR_W + spp_pkg::ROOT_W;
   localparam int NSTAGE = spp_pkg::ROOT_W;
   localparam int REM_W  = spp_pkg::REM_W;
   localparam int ROOT_W = spp_pkg::ROOT_W;
   localparam int MAG_W  = spp_pkg::RADIUS_W;

   logic en;

   // Stage one: z magnitude and the square root radicand.
   logic                              p1_valid_ff;
   logic [spp_pkg::S30_W-1:0]         p1_zabs_ff, p1_zabs_in;
   logic                              p1_zneg_ff, p1_zneg_in;
   logic [spp_pkg::RADICAND_W-1:0]    p1_rad_ff, p1_rad_in;
   logic [B-1:0]                      p1_xm_ff, p1_ym_ff;
   logic                              p1_xneg_ff, p1_yneg_ff;
   logic [spp_pkg::RADIUS_W-1:0]      p1_r_ff;
   logic [31:0]                       s_twice;
   logic [spp_pkg::S30_W-1:0]         s_diff;
   logic [spp_pkg::ZPROD_W-1:0]       z_prod;

   // Square root stages, one root bit each, with the side data beside them.
   logic                  sq_valid_ff [NSTAGE];
   logic [REM_W-1:0]      sq_rem_ff   [NSTAGE];
   logic [ROOT_W-1:0]     sq_root_ff  [NSTAGE];
   logic [XR_W-1:0]       sq_xr_ff    [NSTAGE];
   logic [XR_W-1:0]       sq_yr_ff    [NSTAGE];
   logic [MAG_W-1:0]      sq_zmag_ff  [NSTAGE];
   logic                  sq_xneg_ff  [NSTAGE];
   logic                  sq_yneg_ff  [NSTAGE];
   logic                  sq_zneg_ff  [NSTAGE];

   // Final scaling stage.
   logic                  m_valid_ff;
   logic [MAG_W-1:0]      m_xmag_ff, m_ymag_ff, m_zmag_ff;
   logic                  m_xneg_ff, m_yneg_ff, m_zneg_ff;
   logic [PROD_W-1:0]     x_prod, y_prod;

   // Output register.
   logic                               out_valid_ff;
   logic [spp_pkg::COORD_W-1:0]        out_x_ff, out_y_ff, out_z_ff;
   logic [spp_pkg::COORD_W-1:0]        out_x_in, out_y_in, out_z_in;

   // The back moves as one unless the output word waits to be taken.
   assign en       = !out_valid_ff || out_ready;
   assign in_ready = en;

   // |2S - 1| and 1 - S scaled for a 17-bit root with 16 fraction bits.
   assign s_twice    = {s_q30, 1'b0};
   assign p1_zneg_in = s_twice < 32'(spp_pkg::Q30_ONE);
   assign p1_zabs_in = p1_zneg_in ? spp_pkg::S30_W'(32'(spp_pkg::Q30_ONE) - s_twice)
                                  : spp_pkg::S30_W'(s_twice - 32'(spp_pkg::Q30_ONE));
   assign s_diff     = spp_pkg::Q30_ONE - s_q30;
   assign p1_rad_in  = {s_diff, 2'b00};

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else if (en) begin
         p1_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p1_zabs_ff <= p1_zabs_in;
         p1_zneg_ff <= p1_zneg_in;
         p1_rad_ff  <= p1_rad_in;
         p1_xm_ff   <= x_mag;
         p1_ym_ff   <= y_mag;
         p1_xneg_ff <= x_neg;
         p1_yneg_ff <= y_neg;
         p1_r_ff    <= radius;
      end
   end

   // z is final after one product; x and y take the radius now and the root later.
   assign z_prod = spp_pkg::ZPROD_W'(p1_zabs_ff) * spp_pkg::ZPROD_W'(p1_r_ff);

   generate
      for (genvar k = 0; k < NSTAGE; k++) begin : g_root
         localparam int BIT = ROOT_W - 1 - k;

         logic              prev_valid;
         logic [REM_W-1:0]  prev_rem, term, rem_in;
         logic [ROOT_W-1:0] prev_root, root_in;
         logic [XR_W-1:0]   prev_xr, prev_yr;
         logic [MAG_W-1:0]  prev_zmag;
         logic              prev_xneg, prev_yneg, prev_zneg;
         logic              fits;

         if (k == 0) begin : g_first
            assign prev_valid = p1_valid_ff;
            assign prev_rem   = REM_W'(p1_rad_ff);
            assign prev_root  = '0;
            assign prev_xr    = XR_W'(p1_xm_ff) * XR_W'(p1_r_ff);
            assign prev_yr    = XR_W'(p1_ym_ff) * XR_W'(p1_r_ff);
            assign prev_zmag  = z_prod[spp_pkg::ZPROD_W-2:spp_pkg::ZPROD_W-1-MAG_W];
            assign prev_xneg  = p1_xneg_ff;
            assign prev_yneg  = p1_yneg_ff;
            assign prev_zneg  = p1_zneg_ff;
         end else begin : g_next
            assign prev_valid = sq_valid_ff[k-1];
            assign prev_rem   = sq_rem_ff[k-1];
            assign prev_root  = sq_root_ff[k-1];
            assign prev_xr    = sq_xr_ff[k-1];
            assign prev_yr    = sq_yr_ff[k-1];
            assign prev_zmag  = sq_zmag_ff[k-1];
            assign prev_xneg  = sq_xneg_ff[k-1];
            assign prev_yneg  = sq_yneg_ff[k-1];
            assign prev_zneg  = sq_zneg_ff[k-1];
         end

         // Setting this bit raises root squared by 2*root*2^BIT + 2^(2*BIT).
         assign term    = (REM_W'(prev_root) << (BIT + 1)) + (REM_W'(1) << (2 * BIT));
         assign fits    = prev_rem >= term;
         assign rem_in  = fits ? prev_rem - term : prev_rem;
         assign root_in = fits ? (prev_root | (ROOT_W'(1) << BIT)) : prev_root;

         always_ff @(posedge clock) begin
            if (reset) begin
               sq_valid_ff[k] <= 1'b0;
            end else if (en) begin
               sq_valid_ff[k] <= prev_valid;
            end
         end

         always_ff @(posedge clock) begin
            if (en) begin
               sq_rem_ff[k]  <= rem_in;
               sq_root_ff[k] <= root_in;
               sq_xr_ff[k]   <= prev_xr;
               sq_yr_ff[k]   <= prev_yr;
               sq_zmag_ff[k] <= prev_zmag;
               sq_xneg_ff[k] <= prev_xneg;
               sq_yneg_ff[k] <= prev_yneg;
               sq_zneg_ff[k] <= prev_zneg;
            end
         end
      end
   endgenerate

   // Scale by sqrt(1-S) and drop the fraction bits.
   assign x_prod = PROD_W'(sq_xr_ff[NSTAGE-1]) * PROD_W'(sq_root_ff[NSTAGE-1]);
   assign y_prod = PROD_W'(sq_yr_ff[NSTAGE-1]) * PROD_W'(sq_root_ff[NSTAGE-1]);

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         m_valid_ff   <= sq_valid_ff[NSTAGE-1];
         out_valid_ff <= m_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m_xmag_ff <= x_prod[B+13+MAG_W:B+14];
         m_ymag_ff <= y_prod[B+13+MAG_W:B+14];
         m_zmag_ff <= sq_zmag_ff[NSTAGE-1];
         m_xneg_ff <= sq_xneg_ff[NSTAGE-1];
         m_yneg_ff <= sq_yneg_ff[NSTAGE-1];
         m_zneg_ff <= sq_zneg_ff[NSTAGE-1];
         out_x_ff  <= out_x_in;
         out_y_ff  <= out_y_in;
         out_z_ff  <= out_z_in;
      end
   end

   // Apply the signs; a negative zero comes out as plain zero.
   assign out_x_in = m_xneg_ff ? -{1'b0, m_xmag_ff} : {1'b0, m_xmag_ff};
   assign out_y_in = m_yneg_ff ? -{1'b0, m_ymag_ff} : {1'b0, m_ymag_ff};
   assign out_z_in = m_zneg_ff ? -{1'b0, m_zmag_ff} : {1'b0, m_zmag_ff};

   assign out_valid = out_valid_ff;
   assign coord_x   = out_x_ff;
   assign coord_y   = out_y_ff;
   assign coord_z   = out_z_ff;

endmodule

[rtl/sphere_point_sampler_core.sv]
// Top level of the sphere point sampler.
//
// Each request word carries two uniform fractions and a radius; the block maps them to a
// disc point and either drops the pair (outside the unit disc) or returns one point on
// the sphere surface by Marsaglia's method, in signed Q8.8, rounded toward zero. The
// block takes one request word per cycle and gives at most one response word per cycle
// while the response side keeps up; a dropped pair simply yields no response. A kept
// pair passes three front stages (the first loaded at the edge that takes it), the
// four-entry queue, and a back pipeline whose length is set by the seventeen-stage
// square root, one root bit per stage, plus one stage before it and two after it.
// Response words stay in order of their requests.
module sphere_point_sampler_core #(
   parameter int SAMPLE_BITS = spp_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // Fields from bit 0: first_uniform[15:0], second_uniform[31:16], radius[47:32].
   input  logic [spp_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // Fields from bit 0: coord_x[16:0], coord_y[33:17], coord_z[50:34], zero fill above.
   output logic [spp_pkg::RSP_DATA_W-1:0]     rsp_tdata
);

   localparam int B       = SAMPLE_BITS;
   localparam int QUEUE_W = 2 * B + 2 + spp_pkg::RADIUS_W + spp_pkg::S30_W;

   logic                               f_push_valid, q_push_ready;
   logic [B-1:0]                       f_xm, f_ym, b_xm, b_ym;
   logic                               f_xneg, f_yneg, b_xneg, b_yneg;
   logic [spp_pkg::RADIUS_W-1:0]       f_r, b_r;
   logic [spp_pkg::S30_W-1:0]          f_s30, b_s30;
   logic [QUEUE_W-1:0]                 q_push_data, q_pop_data;
   logic                               q_pop_valid, b_in_ready;
   logic signed [spp_pkg::COORD_W-1:0] coord_x, coord_y, coord_z;

   spp_front #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (req_tvalid),
      .in_ready       (req_tready),
      .first_uniform  (req_tdata[15:0]),
      .second_uniform (req_tdata[31:16]),
      .radius         (req_tdata[47:32]),
      .push_valid     (f_push_valid),
      .push_ready     (q_push_ready),
      .x_mag          (f_xm),
      .y_mag          (f_ym),
      .x_neg          (f_xneg),
      .y_neg          (f_yneg),
      .radius_out     (f_r),
      .s_q30          (f_s30)
   );

   // Queue entries carry the disc point, the radius and S in Q.30.
   assign q_push_data = {f_xm, f_ym, f_xneg, f_yneg, f_r, f_s30};
   assign {b_xm, b_ym, b_xneg, b_yneg, b_r, b_s30} = q_pop_data;

   spp_queue #(
      .WIDTH (QUEUE_W),
      .DEPTH (spp_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_push_valid),
      .push_ready (q_push_ready),
      .push_data  (q_push_data),
      .pop_valid  (q_pop_valid),
      .pop_ready  (b_in_ready),
      .pop_data   (q_pop_data)
   );

   spp_back #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_pop_valid),
      .in_ready  (b_in_ready),
      .x_mag     (b_xm),
      .y_mag     (b_ym),
      .x_neg     (b_xneg),
      .y_neg     (b_yneg),
      .radius    (b_r),
      .s_q30     (b_s30),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .coord_x   (coord_x),
      .coord_y   (coord_y),
      .coord_z   (coord_z)
   );

   // Pack the response word with zero fill to whole bytes.
   assign rsp_tdata = {5'b00000, coord_z, coord_y, coord_x};

endmodule
